### rtl/llt_pkg.sv
// Shared constants, codes and types of the cursor linked list table.
package llt_pkg;

	// Default sizing
	localparam int CAPACITY_DEF  = 16;
	localparam int DATA_BITS_DEF = 32;

	// Fixed field widths
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int CURSOR_W = 5;
	localparam int VALUE_W  = 32;

	// Reserved slots
	localparam int HEAD_SLOT = 0;
	localparam int FREE_SLOT = 1;

	// Commands
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Per-step result flags from the link engine
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                at_end;
		logic                bypass;
	} llt_flags_t;

endpackage

### rtl/cursor_linked_list_table.sv
// Top level of the cursor linked list table.
//
// A singly linked list held in a link table of CAPACITY + 2 slots: slot 0
// heads the data list, slot 1 heads the free chain, and a cursor rests on
// the head or on a data node. Each input transfer carries a command
// (insert after cursor, delete after cursor, advance cursor) and a data
// word; each one yields exactly one result transfer with status, the cursor
// slot, the word after the cursor and an end-of-list flag.
//
// Both channels are valid/ready. An input transfer lands in the input
// register; once the result register is free it is executed against the
// link table and the result register is loaded. One item is taken per
// cycle while the receiver takes each result: the link table is a
// register file whose reads and up to three writes per command complete
// in one update, and the word store is read into the result register.
//
// Reset empties the list, threads every data slot on the free chain and
// puts the cursor on the head. The word store is not cleared. When the
// receiver stalls, the result is held, the input register fills, and
// in_ready drops until the result is taken.
module cursor_linked_list_table #(
	parameter int CAPACITY = llt_pkg::CAPACITY_DEF,
	parameter int DATA_BITS = llt_pkg::DATA_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [llt_pkg::CMD_W-1:0]     cmd,
	input  logic [llt_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [llt_pkg::STATUS_W-1:0]  status,
	output logic [llt_pkg::CURSOR_W-1:0]  cursor_slot,
	output logic [llt_pkg::VALUE_W-1:0]   next_value,
	output logic                          at_end
);

	localparam int SLOTS = CAPACITY + 2;
	localparam int SB = $clog2(SLOTS);

	logic                        valid_s1;
	logic [llt_pkg::CMD_W-1:0]   cmd_s1;
	logic [DATA_BITS-1:0]        word_s1;
	logic                        go;

	llt_pkg::llt_flags_t         flags, flags_q;
	logic [SB-1:0]               cursor_nxt, succ_nxt, word_slot;
	logic [SB-1:0]               cursor_q;
	logic                        word_we;
	logic [DATA_BITS-1:0]        byp_word_q, rd_word;
	logic [63:0]                 value_ext, word_ext;
	logic [15:0]                 cursor_ext;

	// Trim the incoming word to the stored width
	always_comb begin
		value_ext = '0;
		value_ext[llt_pkg::VALUE_W-1:0] = value;
	end

	// Execute when an item waits and the result register is free
	assign go       = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			word_s1 <= value_ext[DATA_BITS-1:0];
		end
	end

	llt_links #(
		.CAPACITY (CAPACITY)
	) u_links (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go),
		.cmd        (cmd_s1),
		.flags      (flags),
		.cursor_nxt (cursor_nxt),
		.succ_nxt   (succ_nxt),
		.word_we    (word_we),
		.word_slot  (word_slot)
	);

	llt_words #(
		.CAPACITY  (CAPACITY),
		.DATA_BITS (DATA_BITS)
	) u_words (
		.clk   (clk),
		.we    (go && word_we),
		.waddr (word_slot),
		.wdata (word_s1),
		.re    (go),
		.raddr (succ_nxt),
		.rdata (rd_word)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (go)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			flags_q    <= flags;
			cursor_q   <= cursor_nxt;
			byp_word_q <= word_s1;
		end
	end

	// Drive the result fields; a fresh insert forwards its own word
	always_comb begin
		word_ext = '0;
		word_ext[DATA_BITS-1:0] = flags_q.bypass ? byp_word_q : rd_word;
		cursor_ext = '0;
		cursor_ext[SB-1:0] = cursor_q;
	end

	assign status      = flags_q.status;
	assign at_end      = flags_q.at_end;
	assign cursor_slot = cursor_ext[llt_pkg::CURSOR_W-1:0];
	assign next_value  = flags_q.at_end ? '0 : word_ext[llt_pkg::VALUE_W-1:0];

endmodule

### rtl/llt_links.sv
// Link table register file, cursor and the combinational list update logic.
module llt_links #(
	parameter int CAPACITY = llt_pkg::CAPACITY_DEF,
	localparam int SLOTS = CAPACITY + 2,
	localparam int SB = $clog2(SLOTS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [llt_pkg::CMD_W-1:0]      cmd,
	output llt_pkg::llt_flags_t            flags,
	output logic [SB-1:0]                  cursor_nxt,
	output logic [SB-1:0]                  succ_nxt,
	output logic                           word_we,
	output logic [SB-1:0]                  word_slot
);

	localparam logic [SB-1:0] HEAD = SB'(llt_pkg::HEAD_SLOT);
	localparam logic [SB-1:0] FREE = SB'(llt_pkg::FREE_SLOT);

	logic [SB-1:0] link_q [SLOTS];
	logic [SB-1:0] cursor_q;

	logic [SB-1:0] succ, first, fhead, fhead2, succ2;
	logic [SB-1:0] del_at, del_node, del_after;
	logic          lwe;
	logic [SB-1:0] wa0, wa1, wa2, wd0, wd1, wd2;

	// Read the links around the cursor, the list head and the free head
	assign succ      = link_q[cursor_q];
	assign first     = link_q[HEAD];
	assign fhead     = link_q[FREE];
	assign fhead2    = link_q[fhead];
	assign succ2     = link_q[succ];
	assign del_at    = (succ == HEAD) ? HEAD : cursor_q;
	assign del_node  = (succ == HEAD) ? first : succ;
	assign del_after = link_q[del_node];

	// Decode the command into up to three link writes and the new cursor
	always_comb begin
		lwe          = 1'b0;
		wa0          = FREE;
		wd0          = fhead;
		wa1          = fhead;
		wd1          = fhead2;
		wa2          = cursor_q;
		wd2          = succ;
		cursor_nxt   = cursor_q;
		succ_nxt     = succ;
		word_we      = 1'b0;
		word_slot    = fhead;
		flags.status = llt_pkg::STATUS_DONE;
		flags.bypass = 1'b0;
		unique case (cmd)
			llt_pkg::CMD_INSERT: begin
				if (fhead == FREE) begin
					flags.status = llt_pkg::STATUS_FULL;
				end else begin
					lwe          = 1'b1;
					word_we      = 1'b1;
					wa0          = FREE;
					wd0          = fhead2;
					wa1          = fhead;
					wd1          = succ;
					wa2          = cursor_q;
					wd2          = fhead;
					succ_nxt     = fhead;
					flags.bypass = 1'b1;
				end
			end
			llt_pkg::CMD_DELETE: begin
				if (first == HEAD) begin
					flags.status = llt_pkg::STATUS_EMPTY;
				end else begin
					lwe        = 1'b1;
					wa0        = del_at;
					wd0        = del_after;
					wa1        = del_node;
					wd1        = fhead;
					wa2        = FREE;
					wd2        = del_node;
					cursor_nxt = del_at;
					succ_nxt   = del_after;
				end
			end
			llt_pkg::CMD_ADVANCE: begin
				cursor_nxt = succ;
				succ_nxt   = succ2;
			end
			default: begin
			end
		endcase
		flags.at_end = (succ_nxt == HEAD);
	end

	// Hold the link table; reset to an empty list and a full free chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (i == llt_pkg::HEAD_SLOT)
					link_q[i] <= HEAD;
				else if (i == SLOTS - 1)
					link_q[i] <= FREE;
				else
					link_q[i] <= SB'(i + 1);
			end
			cursor_q <= HEAD;
		end else if (step) begin
			if (lwe) begin
				link_q[wa0] <= wd0;
				link_q[wa1] <= wd1;
				link_q[wa2] <= wd2;
			end
			cursor_q <= cursor_nxt;
		end
	end

endmodule

### rtl/llt_words.sv
// Word store memory: one write port and one registered read port.
module llt_words #(
	parameter int CAPACITY = llt_pkg::CAPACITY_DEF,
	parameter int DATA_BITS = llt_pkg::DATA_BITS_DEF,
	localparam int SLOTS = CAPACITY + 2,
	localparam int SB = $clog2(SLOTS)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [SB-1:0]        waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [SB-1:0]        raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [SLOTS];

	// Write the stored word and register the read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### rtl/llt_checker.sv
// Port-level checker for the cursor linked list table, bound to the top level.
module llt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [llt_pkg::STATUS_W-1:0]  status,
	input logic [llt_pkg::CURSOR_W-1:0]  cursor_slot,
	input logic [llt_pkg::VALUE_W-1:0]   next_value,
	input logic                          at_end
);

	localparam logic [llt_pkg::CURSOR_W-1:0] HEAD = llt_pkg::CURSOR_W'(llt_pkg::HEAD_SLOT);
	localparam logic [llt_pkg::CURSOR_W-1:0] FREE = llt_pkg::CURSOR_W'(llt_pkg::FREE_SLOT);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cursor_slot)
			&& $stable(next_value) && $stable(at_end))
		else $error("result changed while stalled");

	// No successor means no word
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_end |-> next_value == '0)
		else $error("word reported past the end of the list");

	// An empty list leaves the cursor on the head with nothing after it
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == llt_pkg::STATUS_EMPTY |-> cursor_slot == HEAD && at_end)
		else $error("empty status with a populated cursor");

	// The cursor never rests on the free chain head
	a_not_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_slot != FREE)
		else $error("cursor on the free chain head");

endmodule

bind cursor_linked_list_table llt_checker u_llt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.cursor_slot (cursor_slot),
	.next_value  (next_value),
	.at_end      (at_end)
);
